// ----- rtl/sync_type_length_frame_parser_defines.svh -----
// Assertion macros shared by the frame parser RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef SYNC_TYPE_LENGTH_FRAME_PARSER_DEFINES_SVH
`define SYNC_TYPE_LENGTH_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STLP_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("stlp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define STLP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("stlp: next-cycle check failed");

`endif

// ----- rtl/stlp_pkg.sv -----
// Types, constants and the length-table lookup of the frame parser.
// Used by every RTL file of the block; depends on nothing.
package stlp_pkg;

  // Frame framing constants.
  localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
  localparam logic [3:0]  POS_TYPE   = 4'd2;
  localparam logic [3:0]  POS_BODY   = 4'd3;
  localparam logic [4:0]  LEN_MIN    = 5'd4;

  // Configuration register indexes and reset values.
  localparam logic        CFG_LEN_LO = 1'b0;
  localparam logic        CFG_LEN_HI = 1'b1;
  localparam logic [39:0] RESET_LEN_LO = 40'd15281202699;
  localparam logic [39:0] RESET_LEN_HI = 40'd314606354432;

  // One write into a frame buffer slot.
  typedef struct packed {
    logic       en;
    logic       slot;
    logic [3:0] pos;
    logic [7:0] data;
  } buf_wr_t;

  // A verified frame waiting to be played out.
  typedef struct packed {
    logic       slot;
    logic [3:0] ftype;
    logic [4:0] len;
  } desc_t;

  // Back part hands a slot back to the front part.
  typedef struct packed {
    logic valid;
    logic slot;
  } rel_t;

  // Length of a frame type from the two table registers.
  function automatic logic [4:0] table_len(logic [39:0] lo, logic [39:0] hi, logic [3:0] t);
    logic [39:0] r;
    logic [5:0]  sh;
    r  = t[3] ? hi : lo;
    sh = ({3'b000, t[2:0]} << 2) + {3'b000, t[2:0]};
    return r[sh +: 5];
  endfunction

endpackage

// ----- rtl/stlp_front.sv -----
// Front part of the frame parser: sync hunt, type check, checksum, buffer writes.
// Depends on stlp_pkg; feeds the descriptor queue and the back part's buffer.
module stlp_front #(
  parameter int MAX_FRAME_BYTES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rx_valid_i,
  input  logic [7:0]       rx_byte_i,
  output logic             rx_stall_o,
  input  logic [39:0]      len_lo_i,
  input  logic [39:0]      len_hi_i,
  output stlp_pkg::buf_wr_t wr_o,
  output logic             push_o,
  output stlp_pkg::desc_t  desc_o,
  input  stlp_pkg::rel_t   rel_i
);
  import stlp_pkg::*;

  localparam logic [4:0] LenMax = 5'(MAX_FRAME_BYTES);

  logic [3:0] pos_q, pos_d;
  logic [7:0] sum_q, sum_d;
  logic [3:0] type_q, type_d;
  logic       slot_q, slot_d;
  logic [1:0] busy_q, busy_d;
  logic       acc;
  logic [4:0] new_len, cur_len, pos_ext;
  logic       new_ok, cur_ok;

  // A slot still held by the back part blocks new bytes.
  assign rx_stall_o = busy_q[slot_q];
  assign acc        = rx_valid_i && !rx_stall_o;

  // Table lengths for the incoming type byte and for the current frame.
  assign new_len = table_len(len_lo_i, len_hi_i, rx_byte_i[3:0]);
  assign cur_len = table_len(len_lo_i, len_hi_i, type_q);
  assign new_ok  = (new_len >= LEN_MIN) && (new_len <= LenMax);
  assign cur_ok  = (cur_len >= LEN_MIN) && (cur_len <= LenMax);
  assign pos_ext = {1'b0, pos_q};

  assign desc_o.slot  = slot_q;
  assign desc_o.ftype = type_q;
  assign desc_o.len   = cur_len;

  // Parser next state.
  always_comb begin
    pos_d      = pos_q;
    sum_d      = sum_q;
    type_d     = type_q;
    slot_d     = slot_q;
    busy_d     = busy_q;
    push_o     = 1'b0;
    wr_o.en    = 1'b0;
    wr_o.slot  = slot_q;
    wr_o.pos   = pos_q;
    wr_o.data  = rx_byte_i;
    if (rel_i.valid) begin
      busy_d[rel_i.slot] = 1'b0;
    end
    if (acc) begin
      if (pos_q < POS_TYPE) begin
        if (rx_byte_i == SYNC_BYTE) begin
          wr_o.en = 1'b1;
          sum_d   = sum_q + rx_byte_i;
          pos_d   = pos_q + 4'd1;
        end else begin
          pos_d = '0;
          sum_d = '0;
        end
      end else if (pos_q == POS_TYPE) begin
        if (rx_byte_i[7:4] != 4'd0 || !new_ok) begin
          pos_d = '0;
          sum_d = '0;
        end else begin
          wr_o.en = 1'b1;
          type_d  = rx_byte_i[3:0];
          sum_d   = sum_q + rx_byte_i;
          pos_d   = POS_BODY;
        end
      end else begin
        if (!cur_ok || pos_ext >= cur_len) begin
          // The table changed under a running frame.
          pos_d = '0;
          sum_d = '0;
        end else begin
          wr_o.en = 1'b1;
          if (pos_ext + 5'd1 < cur_len) begin
            sum_d = sum_q + rx_byte_i;
            pos_d = pos_q + 4'd1;
          end else begin
            // Checksum byte: a match hands the slot to the back part.
            if (sum_q == rx_byte_i) begin
              push_o         = 1'b1;
              busy_d[slot_q] = 1'b1;
              slot_d         = ~slot_q;
            end
            pos_d = '0;
            sum_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      type_q <= '0;
      slot_q <= 1'b0;
      busy_q <= '0;
    end else begin
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      type_q <= type_d;
      slot_q <= slot_d;
      busy_q <= busy_d;
    end
  end

endmodule

// ----- rtl/stlp_desc_fifo.sv -----
// Two-entry queue of verified frame descriptors between front and back.
// Depends on stlp_pkg for the descriptor type.
module stlp_desc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  stlp_pkg::desc_t desc_i,
  input  logic            pop_i,
  output stlp_pkg::desc_t desc_o,
  output logic            empty_o,
  output logic            full_o
);
  import stlp_pkg::*;

  desc_t      entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign desc_o  = entry_q[rd_ptr_q];
  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= desc_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/stlp_back.sv -----
// Back part of the frame parser: two frame buffers and the byte play-out.
// Depends on stlp_pkg; takes descriptors from stlp_desc_fifo.
module stlp_back #(
  parameter int MAX_FRAME_BYTES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stlp_pkg::buf_wr_t wr_i,
  input  stlp_pkg::desc_t   desc_i,
  input  logic              desc_empty_i,
  output logic              pop_o,
  output stlp_pkg::rel_t    rel_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        frame_byte_o,
  output logic [3:0]        byte_position_o,
  output logic [3:0]        frame_type_o,
  output logic              last_byte_o
);
  import stlp_pkg::*;

  localparam int IdxW = $clog2(MAX_FRAME_BYTES);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  // Each slot spans a power-of-two range so the slot bit can lead the address.
  logic [7:0] mem [2 << IdxW];

  state_e     state_q;
  desc_t      cur_q;
  logic [3:0] k_q;
  logic       out_valid_q;
  logic [7:0] byte_q;
  logic [3:0] bpos_q;
  logic [3:0] ftype_q;
  logic       last_q;
  logic       load;
  logic       is_last;

  assign out_valid_o     = out_valid_q;
  assign frame_byte_o    = byte_q;
  assign byte_position_o = bpos_q;
  assign frame_type_o    = ftype_q;
  assign last_byte_o     = last_q;

  // The output register takes a byte when it is empty or being drained.
  assign load    = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign is_last = ({1'b0, k_q} + 5'd1 == cur_q.len);
  assign pop_o   = (state_q == ST_IDLE) && !desc_empty_i;

  // The slot is free once its last byte sits in the output register.
  assign rel_o.valid = load && is_last;
  assign rel_o.slot  = cur_q.slot;

  // Frame buffer writes from the front part.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[{wr_i.slot, wr_i.pos[IdxW-1:0]}] <= wr_i.data;
    end
  end

  // Play-out sequencer with the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      cur_q       <= '0;
      byte_q      <= '0;
      bpos_q      <= '0;
      ftype_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
          if (!desc_empty_i) begin
            cur_q   <= desc_i;
            k_q     <= '0;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load) begin
            out_valid_q <= 1'b1;
            byte_q      <= mem[{cur_q.slot, k_q[IdxW-1:0]}];
            bpos_q      <= k_q;
            ftype_q     <= cur_q.ftype;
            last_q      <= is_last;
            k_q         <= k_q + 4'd1;
            if (is_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/sync_type_length_frame_parser.sv -----
// Top level of the sync/type/length frame parser with an additive checksum.
// Depends on stlp_pkg, stlp_front, stlp_desc_fifo, stlp_back and the defines header.
//
//   Channel   Direction  Handshake                     Payload
//   rx        in         rx_valid_i / rx_stall_o       rx_byte_i
//   out       out        out_valid_o / out_stall_i     frame_byte_o, byte_position_o,
//                                                      frame_type_o, last_byte_o
//   config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// A verified frame plays out at one byte per cycle while out_stall_i is low; its first
// byte passes through the descriptor queue and the play-out state into the output register.
// rx_stall_o rises only while both frame buffers hold frames that are still being played out.
// Reset clears the parser to hunting, empties the queue and the output register, and
// loads the length table defaults; no clearing pass is needed.
`include "sync_type_length_frame_parser_defines.svh"

module sync_type_length_frame_parser #(
  parameter int MAX_FRAME_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic [3:0]  byte_position_o,
  output logic [3:0]  frame_type_o,
  output logic        last_byte_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import stlp_pkg::*;

  logic [39:0] len_lo_q, len_hi_q;
  logic        cfg_wr;
  buf_wr_t     buf_wr;
  desc_t       push_desc, head_desc;
  logic        fifo_push, fifo_pop, fifo_empty, fifo_full;
  rel_t        rel;

  // Length table registers; a register sits at each eight-byte step.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[3] == CFG_LEN_HI) ? {24'd0, len_hi_q} : {24'd0, len_lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_lo_q <= RESET_LEN_LO;
      len_hi_q <= RESET_LEN_HI;
    end else if (cfg_wr) begin
      if (paddr[3] == CFG_LEN_HI) begin
        len_hi_q <= pwdata[39:0];
      end else begin
        len_lo_q <= pwdata[39:0];
      end
    end
  end

  // Front part: hunting, checking and buffer writes.
  stlp_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_valid_i(rx_valid_i),
    .rx_byte_i (rx_byte_i),
    .rx_stall_o(rx_stall_o),
    .len_lo_i  (len_lo_q),
    .len_hi_i  (len_hi_q),
    .wr_o      (buf_wr),
    .push_o    (fifo_push),
    .desc_o    (push_desc),
    .rel_i     (rel)
  );

  // Queue of verified frames.
  stlp_desc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fifo_push),
    .desc_i (push_desc),
    .pop_i  (fifo_pop),
    .desc_o (head_desc),
    .empty_o(fifo_empty),
    .full_o (fifo_full)
  );

  // Back part: frame buffers and play-out.
  stlp_back #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_i           (buf_wr),
    .desc_i         (head_desc),
    .desc_empty_i   (fifo_empty),
    .pop_o          (fifo_pop),
    .rel_o          (rel),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_byte_o   (frame_byte_o),
    .byte_position_o(byte_position_o),
    .frame_type_o   (frame_type_o),
    .last_byte_o    (last_byte_o)
  );

  // The slot accounting must keep the queue from overflowing.
  `STLP_ASSERT_NOW(a_push_has_room, clk_i, rst_ni, fifo_push, !fifo_full)
  // Once a frame has started, its bytes follow without a gap while drained.
  `STLP_ASSERT_NEXT(a_frame_no_gap, clk_i, rst_ni, out_valid_o && !out_stall_i && !last_byte_o, out_valid_o)
  // The first byte of every frame is a sync byte.
  `STLP_ASSERT_NOW(a_first_is_sync, clk_i, rst_ni, out_valid_o && byte_position_o == 4'd0, frame_byte_o == SYNC_BYTE)

endmodule
